// ----- rtl/core/lwcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lwcc_pkg
// Shared types and constants for the line, word and character counter.
// ----------------------------------------------------------------------------
package lwcc_pkg;

    // Width of each count field on the result channel.
    localparam int unsigned FIELD_W = 48;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Byte values of interest.
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // Allowed range of the next UTF-8 continuation byte.
    typedef enum logic [2:0] {
        CLS_80_BF = 3'd0,
        CLS_A0_BF = 3'd1,
        CLS_80_9F = 3'd2,
        CLS_90_BF = 3'd3,
        CLS_80_8F = 3'd4
    } cont_cls_t;

    // State of the UTF-8 decoder between bytes.
    typedef struct packed {
        logic [1:0] pending;
        logic [1:0] needed;
        cont_cls_t  cls;
    } dec_state_t;

    localparam dec_state_t DEC_IDLE = '{pending: 2'd0, needed: 2'd0, cls: CLS_80_BF};

endpackage

// ----- rtl/core/lwcc_sat_add.sv -----
// ----------------------------------------------------------------------------
// lwcc_sat_add
// Saturating add of a small amount to a count, with an overflow indication.
// ----------------------------------------------------------------------------
module lwcc_sat_add #(
    parameter int unsigned COUNT_WIDTH = 48
) (
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [2:0]             amount,
    output logic [COUNT_WIDTH-1:0] sum,
    output logic                   sat
);

    logic [COUNT_WIDTH:0] wide_sum;

    // A carry out of the top bit means the count would pass its maximum.
    assign wide_sum = {1'b0, count} + {{(COUNT_WIDTH-2){1'b0}}, amount};
    assign sat      = wide_sum[COUNT_WIDTH];
    assign sum      = sat ? {COUNT_WIDTH{1'b1}} : wide_sum[COUNT_WIDTH-1:0];

endmodule

// ----- rtl/core/lwcc_utf8_dec.sv -----
// ----------------------------------------------------------------------------
// lwcc_utf8_dec
// Strict UTF-8 decoder step: next decoder state and the number of units that
// one byte (or the end of the stream) adds to the unit count.
// ----------------------------------------------------------------------------
module lwcc_utf8_dec
    import lwcc_pkg::*;
(
    input  logic       char_mode,
    input  logic       eos,
    input  logic [7:0] data_byte,
    input  dec_state_t state_cur,
    output dec_state_t state_nxt,
    output logic [2:0] amount
);

    logic       lead_single;
    dec_state_t lead_state;
    logic       cont_ok;

    // Classify the byte as a lead byte.
    always_comb
    begin
        lead_single = 1'b0;
        lead_state  = DEC_IDLE;
        if (data_byte < 8'hC2 || data_byte >= 8'hF5) begin
            lead_single = 1'b1;
        end else if (data_byte <= 8'hDF) begin
            lead_state.pending = 2'd1;
            lead_state.needed  = 2'd1;
        end else if (data_byte <= 8'hEF) begin
            lead_state.pending = 2'd1;
            lead_state.needed  = 2'd2;
            if (data_byte == 8'hE0) begin
                lead_state.cls = CLS_A0_BF;
            end else if (data_byte == 8'hED) begin
                lead_state.cls = CLS_80_9F;
            end
        end else begin
            lead_state.pending = 2'd1;
            lead_state.needed  = 2'd3;
            if (data_byte == 8'hF0) begin
                lead_state.cls = CLS_90_BF;
            end else if (data_byte == 8'hF4) begin
                lead_state.cls = CLS_80_8F;
            end
        end
    end

    // Check the byte against the allowed continuation range.
    always_comb
    begin
        case (state_cur.cls)
            CLS_A0_BF: cont_ok = data_byte inside {[8'hA0:8'hBF]};
            CLS_80_9F: cont_ok = data_byte inside {[8'h80:8'h9F]};
            CLS_90_BF: cont_ok = data_byte inside {[8'h90:8'hBF]};
            CLS_80_8F: cont_ok = data_byte inside {[8'h80:8'h8F]};
            default:   cont_ok = data_byte inside {[8'h80:8'hBF]};
        endcase
    end

    // Decoder step.
    always_comb
    begin
        state_nxt = DEC_IDLE;
        amount    = 3'd0;
        if (eos) begin
            // Held bytes of an unfinished sequence count one each.
            amount = {1'b0, state_cur.pending};
        end else if (!char_mode) begin
            amount = {1'b0, state_cur.pending} + 3'd1;
        end else if (state_cur.needed == 2'd0) begin
            state_nxt = lead_state;
            amount    = {2'b00, lead_single};
        end else if (cont_ok) begin
            if (state_cur.needed == 2'd1) begin
                amount = 3'd1;
            end else begin
                state_nxt.pending = state_cur.pending + 2'd1;
                state_nxt.needed  = state_cur.needed - 2'd1;
                state_nxt.cls     = CLS_80_BF;
            end
        end else begin
            // Broken sequence: flush held bytes, then decode as a new lead.
            state_nxt = lead_state;
            amount    = {1'b0, state_cur.pending} + {2'b00, lead_single};
        end
    end

endmodule

// ----- rtl/core/line_word_char_counter_core.sv -----
// ----------------------------------------------------------------------------
// line_word_char_counter_core
// Counts lines, words and bytes or UTF-8 characters over a byte stream and
// reports the counts on each end-of-stream transaction.
// ----------------------------------------------------------------------------
//  Channel  Signals                                         Direction
//  in       in_valid, in_stall, kind, data_byte             into the core
//  out      out_valid, out_stall, line_count, word_count,
//           unit_count, overflow                            out of the core
//  cfg      cfg_wr_en, cfg_wr_data (char_mode)              into the core
//
// One input transaction is accepted every cycle unless in_stall is high; the
// counts and the decoder are updated at the accepting edge, and an
// end-of-stream transaction loads the result register, whose contents appear
// on the next cycle. Reset clears all counts, the decoder, the mode register
// and out_valid. While a result waits under out_stall, data bytes are still
// taken; only a further end-of-stream transaction is held off by in_stall.
// ----------------------------------------------------------------------------
module line_word_char_counter_core
    import lwcc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIELD_W-1:0] line_count,
    output logic [FIELD_W-1:0] word_count,
    output logic [FIELD_W-1:0] unit_count,
    output logic               overflow
);

    logic                   char_mode_reg;
    logic [COUNT_WIDTH-1:0] line_reg;
    logic [COUNT_WIDTH-1:0] word_reg;
    logic [COUNT_WIDTH-1:0] unit_reg;
    logic                   inside_word_reg;
    logic                   saturated_reg;
    dec_state_t             dec_reg;
    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     line_out_reg;
    logic [FIELD_W-1:0]     word_out_reg;
    logic [FIELD_W-1:0]     unit_out_reg;
    logic                   overflow_reg;

    logic                   accept;
    logic                   eos;
    logic                   is_space;
    logic                   word_start;
    logic [2:0]             line_amt;
    logic [2:0]             word_amt;
    logic [2:0]             unit_amt;
    logic [COUNT_WIDTH-1:0] line_next;
    logic [COUNT_WIDTH-1:0] word_next;
    logic [COUNT_WIDTH-1:0] unit_next;
    logic                   line_sat;
    logic                   word_sat;
    logic                   unit_sat;
    dec_state_t             dec_next;
    logic [FIELD_W-1:0]     line_fit;
    logic [FIELD_W-1:0]     word_fit;
    logic [FIELD_W-1:0]     unit_fit;

    // Handshake: only an end-of-stream transaction needs the result register.
    assign in_stall = out_valid_reg && out_stall && (kind == KIND_EOS);
    assign accept   = in_valid && !in_stall;
    assign eos      = (kind == KIND_EOS);

    // Byte classification for lines and words.
    assign is_space   = (data_byte == BYTE_SPACE) || (data_byte inside {[8'h09:8'h0D]});
    assign word_start = !eos && !is_space && !inside_word_reg;
    assign line_amt   = {2'b00, !eos && (data_byte == BYTE_LF)};
    assign word_amt   = {2'b00, word_start};

    // UTF-8 decoder step.
    lwcc_utf8_dec u_dec (
        .char_mode (char_mode_reg),
        .eos       (eos),
        .data_byte (data_byte),
        .state_cur (dec_reg),
        .state_nxt (dec_next),
        .amount    (unit_amt)
    );

    // Saturating count updates.
    lwcc_sat_add #(.COUNT_WIDTH(COUNT_WIDTH)) u_line_add (
        .count  (line_reg),
        .amount (line_amt),
        .sum    (line_next),
        .sat    (line_sat)
    );

    lwcc_sat_add #(.COUNT_WIDTH(COUNT_WIDTH)) u_word_add (
        .count  (word_reg),
        .amount (word_amt),
        .sum    (word_next),
        .sat    (word_sat)
    );

    lwcc_sat_add #(.COUNT_WIDTH(COUNT_WIDTH)) u_unit_add (
        .count  (unit_reg),
        .amount (unit_amt),
        .sum    (unit_next),
        .sat    (unit_sat)
    );

    // Fit the counts to the width of the result fields.
    generate
        if (COUNT_WIDTH >= FIELD_W) begin : g_trunc
            assign line_fit = line_next[FIELD_W-1:0];
            assign word_fit = word_next[FIELD_W-1:0];
            assign unit_fit = unit_next[FIELD_W-1:0];
        end else begin : g_ext
            assign line_fit = {{(FIELD_W-COUNT_WIDTH){1'b0}}, line_next};
            assign word_fit = {{(FIELD_W-COUNT_WIDTH){1'b0}}, word_next};
            assign unit_fit = {{(FIELD_W-COUNT_WIDTH){1'b0}}, unit_next};
        end
    endgenerate

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            char_mode_reg <= cfg_wr_data;
        end
    end

    // Stream state: counts, word flag, decoder and saturation flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg        <= '0;
            word_reg        <= '0;
            unit_reg        <= '0;
            inside_word_reg <= 1'b0;
            saturated_reg   <= 1'b0;
            dec_reg         <= DEC_IDLE;
        end else if (accept) begin
            if (eos) begin
                line_reg        <= '0;
                word_reg        <= '0;
                unit_reg        <= '0;
                inside_word_reg <= 1'b0;
                saturated_reg   <= 1'b0;
                dec_reg         <= DEC_IDLE;
            end else begin
                line_reg        <= line_next;
                word_reg        <= word_next;
                unit_reg        <= unit_next;
                inside_word_reg <= !is_space;
                saturated_reg   <= saturated_reg | line_sat | word_sat | unit_sat;
                dec_reg         <= dec_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept && eos) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded by an end-of-stream transaction.
    always_ff @(posedge clk)
    begin
        if (accept && eos) begin
            line_out_reg <= line_fit;
            word_out_reg <= word_fit;
            unit_out_reg <= unit_fit;
            overflow_reg <= saturated_reg | unit_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_count = line_out_reg;
    assign word_count = word_out_reg;
    assign unit_count = unit_out_reg;
    assign overflow   = overflow_reg;

endmodule

// ----- tb/lwcc_tally_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwcc_tally_checker
// Watches the configuration, input and result channels of the counter, keeps
// its own model of the three counts and of the UTF-8 decoder, and compares
// every result transaction with the oldest outstanding expected tally.
// ----------------------------------------------------------------------------
module lwcc_tally_checker
    import lwcc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [FIELD_W-1:0] line_count,
    input  logic [FIELD_W-1:0] word_count,
    input  logic [FIELD_W-1:0] unit_count,
    input  logic               overflow,
    output int unsigned        fail_count,
    output int unsigned        awaited
);

    localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);

    typedef struct packed {
        logic [FIELD_W-1:0] lines;
        logic [FIELD_W-1:0] words;
        logic [FIELD_W-1:0] units;
        logic               ovf;
    } tally_t;

    tally_t      awaited_tallies [$];

    // Model state of the counter.
    logic        utf8_mode;
    logic [63:0] n_lines;
    logic [63:0] n_words;
    logic [63:0] n_units;
    logic        in_word;
    logic        saturated;
    dec_state_t  dec;

    // Saturating add; a clipped sum marks the stream as saturated.
    function automatic logic [63:0] bump(input logic [63:0] cnt, input logic [63:0] amt);
        if (cnt > CNT_MAX || amt > CNT_MAX - cnt)
        begin
            saturated = 1'b1;
            return CNT_MAX;
        end
        return cnt + amt;
    endfunction

    // Whether a byte lies in the continuation range the decoder allows next.
    function automatic bit cont_fits(input logic [7:0] b, input cont_cls_t cls);
        case (cls)
            CLS_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
            CLS_80_9F: return b >= 8'h80 && b <= 8'h9F;
            CLS_90_BF: return b >= 8'h90 && b <= 8'hBF;
            CLS_80_8F: return b >= 8'h80 && b <= 8'h8F;
            default:   return b >= 8'h80 && b <= 8'hBF;
        endcase
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fail_count < 40)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Bytes held in an open sequence count as one character each.
    task automatic flush_held();
        if (dec.pending != 2'd0)
            n_units = bump(n_units, 64'(dec.pending));
        dec = DEC_IDLE;
    endtask

    // A byte seen with no sequence open.
    task automatic open_lead(input logic [7:0] b);
        if (b <= 8'hC1 || b >= 8'hF5)
        begin
            // ASCII and bad lead bytes are one character on their own.
            n_units = bump(n_units, 64'd1);
            dec = DEC_IDLE;
        end
        else
        begin
            dec.pending = 2'd1;
            if (b <= 8'hDF)
            begin
                dec.needed = 2'd1;
                dec.cls    = CLS_80_BF;
            end
            else if (b <= 8'hEF)
            begin
                dec.needed = 2'd2;
                dec.cls    = (b == 8'hE0) ? CLS_A0_BF : (b == 8'hED) ? CLS_80_9F : CLS_80_BF;
            end
            else
            begin
                dec.needed = 2'd3;
                dec.cls    = (b == 8'hF0) ? CLS_90_BF : (b == 8'hF4) ? CLS_80_8F : CLS_80_BF;
            end
        end
    endtask

    task automatic decode_utf8(input logic [7:0] b);
        if (dec.needed == 2'd0)
            open_lead(b);
        else if (cont_fits(b, dec.cls))
        begin
            dec.needed = dec.needed - 2'd1;
            if (dec.needed == 2'd0)
            begin
                n_units = bump(n_units, 64'd1);
                dec = DEC_IDLE;
            end
            else
            begin
                dec.pending = dec.pending + 2'd1;
                dec.cls     = CLS_80_BF;
            end
        end
        else
        begin
            // A broken sequence: the held bytes count, then this byte leads anew.
            flush_held();
            open_lead(b);
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (b == BYTE_LF)
            n_lines = bump(n_lines, 64'd1);
        if (b == BYTE_SPACE || (b >= 8'h09 && b <= 8'h0D))
            in_word = 1'b0;
        else if (!in_word)
        begin
            in_word = 1'b1;
            n_words = bump(n_words, 64'd1);
        end
        if (utf8_mode)
            decode_utf8(b);
        else
        begin
            flush_held();
            n_units = bump(n_units, 64'd1);
        end
    endtask

    task automatic clear_stream();
        n_lines   = '0;
        n_words   = '0;
        n_units   = '0;
        in_word   = 1'b0;
        saturated = 1'b0;
        dec       = DEC_IDLE;
    endtask

    // End of stream: an incomplete sequence counts per byte, then the tally is due.
    task automatic close_stream();
        tally_t due;
        flush_held();
        due.lines = n_lines[FIELD_W-1:0];
        due.words = n_words[FIELD_W-1:0];
        due.units = n_units[FIELD_W-1:0];
        due.ovf   = saturated;
        awaited_tallies.push_back(due);
        clear_stream();
    endtask

    task automatic check_result();
        tally_t want;
        if (awaited_tallies.size() == 0)
        begin
            report("result with none awaited, line_count", 64'(line_count), 64'd0);
            return;
        end
        want = awaited_tallies.pop_front();
        if (line_count !== want.lines)
            report("line_count", 64'(line_count), 64'(want.lines));
        if (word_count !== want.words)
            report("word_count", 64'(word_count), 64'(want.words));
        if (unit_count !== want.units)
            report("unit_count", 64'(unit_count), 64'(want.units));
        if (overflow !== want.ovf)
            report("overflow", 64'(overflow), 64'(want.ovf));
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_mode = 1'b0;
            clear_stream();
            awaited_tallies.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_EOS)
                    close_stream();
                else
                    absorb_byte(data_byte);
            end
            if (out_valid && !out_stall)
                check_result();
            // A mode write applies from the next data byte on.
            if (cfg_wr_en)
                utf8_mode = cfg_wr_data;
        end
        awaited = awaited_tallies.size();
    end

endmodule

// ----- tb/tb_line_word_char_counter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_word_char_counter_core
// Drives byte streams into the line, word and character counter with random
// gaps and result back-pressure, switching between byte and UTF-8 character
// mode. A directed part covers whitespace, lead-byte classes, broken and
// incomplete sequences and a mid-sequence mode change; random streams
// follow. The checker module predicts each tally and reports any difference.
// ----------------------------------------------------------------------------
module tb_line_word_char_counter_core;
    import lwcc_pkg::*;

    // Counters narrower than the result fields, so the counts are zero-extended.
    localparam int unsigned CNT_W      = 16;
    localparam int          IDLE_LIMIT = 1000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               kind        = KIND_DATA;
    logic [7:0]         data_byte   = 8'h00;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [FIELD_W-1:0] line_count;
    logic [FIELD_W-1:0] word_count;
    logic [FIELD_W-1:0] unit_count;
    logic               overflow;

    int unsigned        fail_count;
    int unsigned        awaited;
    bit                 calm        = 1'b0;
    int                 items_sent  = 0;
    int                 quiet_cycles = 0;
    int                 stall_left  = 0;
    bit                 stall_on    = 1'b0;

    always #6 clk = ~clk;

    line_word_char_counter_core #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_count  (line_count),
        .word_count  (word_count),
        .unit_count  (unit_count),
        .overflow    (overflow)
    );

    lwcc_tally_checker #(
        .COUNT_WIDTH (CNT_W)
    ) tally_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_count  (line_count),
        .word_count  (word_count),
        .unit_count  (unit_count),
        .overflow    (overflow),
        .fail_count  (fail_count),
        .awaited     (awaited)
    );

    // Result back-pressure: short and occasional long stalls between open runs.
    always @(negedge clk)
    begin
        if (calm)
        begin
            stall_on   = 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else if (stall_on)
        begin
            stall_on   = 1'b0;
            stall_left = $urandom_range(1, 20);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_on   = 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end
        else
            stall_left = $urandom_range(1, 6);
        out_stall <= stall_on;
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transaction: optional gap, then hold until accepted.
    task automatic push_item(input logic k, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic push_eos();
        push_item(KIND_EOS, 8'($urandom_range(0, 255)));
    endtask

    // Sends the lowest n bytes of seq, the most significant of them first.
    task automatic send_bytes(input logic [255:0] seq, input int n);
        for (int i = n - 1; i >= 0; i--)
            push_item(KIND_DATA, seq[i*8 +: 8]);
    endtask

    // Holds the sender off until every expected tally has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
    endtask

    task automatic set_mode(input logic utf8);
        drain();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= utf8;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One symbol: mostly ASCII or well-formed UTF-8, some truncated or noise.
    task automatic send_symbol();
        logic [7:0] seq [4];
        int         len;
        int         r;
        r   = $urandom_range(0, 99);
        len = 1;
        if (r < 40)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       seq[0] = BYTE_SPACE;
                    1:       seq[0] = BYTE_LF;
                    default: seq[0] = 8'($urandom_range(9, 13));
                endcase
            end
            else
                seq[0] = 8'($urandom_range(0, 127));
        end
        else if (r < 93)
        begin
            if (r < 55)
                len = 2;
            else if (r < 72)
                len = 3;
            else if (r < 85)
                len = 4;
            else
                len = $urandom_range(2, 4);
            case (len)
                2:       seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
                3:       seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
                default: seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
            endcase
            for (int i = 1; i < 4; i++)
                seq[i] = 8'($urandom_range(8'h80, 8'hBF));
            // Leads with a narrowed second-byte range.
            case (seq[0])
                8'hE0:   seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
                8'hED:   seq[1] = 8'($urandom_range(8'h80, 8'h9F));
                8'hF0:   seq[1] = 8'($urandom_range(8'h90, 8'hBF));
                8'hF4:   seq[1] = 8'($urandom_range(8'h80, 8'h8F));
                default: ;
            endcase
            if (r >= 85)
                len = $urandom_range(1, len - 1);
        end
        else
            seq[0] = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
            push_item(KIND_DATA, seq[i]);
    endtask

    initial
    begin
        bit plan [6];
        int stream_len;
        int start;
        int phase_start;
        plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Byte mode: extremes, newline and each whitespace boundary, an empty stream.
        send_bytes(256'({8'h00, 8'hFF, BYTE_LF, BYTE_SPACE, 8'h09, 8'h0D, 8'h41, 8'h42}),
                   8);
        push_eos();
        push_eos();

        // Character mode: narrowed second bytes, broken sequences, bad leads,
        // and an incomplete sequence closed by end of stream.
        set_mode(1'b1);
        send_bytes(256'({8'hC3, 8'hA9, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'hF0, 8'h8F,
                         8'hF4, 8'h90, 8'hC1, 8'hF5, 8'hE2, 8'h82}), 15);
        push_eos();

        // Byte mode entered with a sequence still open.
        send_bytes(256'({8'hF0, 8'h90}), 2);
        set_mode(1'b0);
        push_item(KIND_DATA, 8'h41);
        push_eos();

        // Random streams in both modes; one phase without idling.
        for (int p = 0; p < 6; p++)
        begin
            set_mode(plan[p]);
            calm        = (p == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < 235)
            begin
                stream_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(0, 25);
                start = items_sent;
                while (items_sent - start < stream_len)
                    send_symbol();
                push_eos();
                if ($urandom_range(0, 15) == 0)
                    drain();
            end
            calm = 1'b0;
        end

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
